[sv/tscf_pkg.sv]
// tscf_pkg: shared types, constants and helper functions for the text stream
// cat filter (front classifier, job queue, back byte sequencer, top level).
// No dependencies.
package tscf_pkg;

    // Line number width in BCD digits
    localparam int NUMBER_DIGITS = 6;
    localparam int NUM_W         = 4 * NUMBER_DIGITS;

    // Expansion of one input byte: at most "M-^x"
    localparam int EXP_MAX   = 4;
    localparam int EXP_IDX_W = $clog2(EXP_MAX);
    localparam int EXP_CNT_W = $clog2(EXP_MAX + 1);

    // Output bytes per input byte: number, tab, expansion
    localparam int MAX_OUT = NUMBER_DIGITS + 1 + EXP_MAX;
    localparam int POS_W   = $clog2(MAX_OUT + 1);

    // Job queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Configuration register file
    localparam int NUM_REGS  = 6;
    localparam int PADDR_W   = $clog2(4 * NUM_REGS);
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam int PDATA_W   = 32;

    localparam logic [REG_IDX_W-1:0] REG_NUMBER_NONBLANK  = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_NUMBER_ALL       = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_SQUEEZE_BLANK    = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_SHOW_ENDS        = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_SHOW_TABS        = REG_IDX_W'(4);
    localparam logic [REG_IDX_W-1:0] REG_SHOW_NONPRINTING = REG_IDX_W'(5);

    // Character codes
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_NL     = 8'd10;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_DOLLAR = 8'd36;
    localparam logic [7:0] CH_DASH   = 8'd45;
    localparam logic [7:0] CH_ZERO   = 8'd48;
    localparam logic [7:0] CH_QMARK  = 8'd63;
    localparam logic [7:0] CH_I      = 8'd73;
    localparam logic [7:0] CH_M      = 8'd77;
    localparam logic [7:0] CH_CARET  = 8'd94;
    localparam logic [7:0] CH_DEL    = 8'd127;
    localparam logic [7:0] CH_HIGH   = 8'd128;
    localparam logic [7:0] CH_META   = 8'd160;
    localparam logic [7:0] CH_MAX    = 8'd255;
    localparam logic [7:0] CTRL_OFS  = 8'd64;

    typedef struct packed {
        logic number_nonblank;
        logic number_all;
        logic squeeze_blank;
        logic show_ends;
        logic show_tabs;
        logic show_nonprinting;
    } cfg_t;

    typedef struct packed {
        logic [EXP_MAX-1:0][7:0] bytes;   // bytes[0] goes out first
        logic [EXP_CNT_W-1:0]    cnt;     // 1..EXP_MAX
    } exp_t;

    // One queued transaction worth of output
    typedef struct packed {
        logic                     has_num;
        logic [NUM_W-1:0]         num;    // BCD, digit 0 is least significant
        logic [NUMBER_DIGITS-1:0] lead;   // 1: digit position shows a space
        exp_t                     exp;
    } job_t;

    function automatic logic [NUM_W-1:0] bcd_inc(input logic [NUM_W-1:0] v);
        logic [NUM_W-1:0] r;
        logic             carry;
        r     = v;
        carry = 1'b1;
        for (int d = 0; d < NUMBER_DIGITS; d++) begin
            if (carry) begin
                if (r[4*d +: 4] < 4'd9) begin
                    r[4*d +: 4] = r[4*d +: 4] + 4'd1;
                    carry       = 1'b0;
                end
                else begin
                    r[4*d +: 4] = 4'd0;
                end
            end
        end
        return r;
    endfunction

    // Leading-space mask: digits above the top nonzero digit are blanked,
    // the units digit always shows.
    function automatic logic [NUMBER_DIGITS-1:0] lead_mask(input logic [NUM_W-1:0] v);
        logic [NUMBER_DIGITS-1:0] m;
        logic                     zero_so_far;
        m           = '0;
        zero_so_far = 1'b1;
        for (int d = NUMBER_DIGITS - 1; d >= 0; d--) begin
            zero_so_far = zero_so_far && (v[4*d +: 4] == 4'd0);
            m[d]        = (d > 0) && zero_so_far;
        end
        return m;
    endfunction

    function automatic exp_t expand(input logic [7:0] c, input cfg_t cfg);
        exp_t e;
        e.bytes = '0;
        e.cnt   = EXP_CNT_W'(1);
        e.bytes[0] = c;
        if (c == CH_NL) begin
            if (cfg.show_ends) begin
                e.bytes[0] = CH_DOLLAR;
                e.bytes[1] = CH_NL;
                e.cnt      = EXP_CNT_W'(2);
            end
        end
        else if (c == CH_TAB && cfg.show_tabs) begin
            e.bytes[0] = CH_CARET;
            e.bytes[1] = CH_I;
            e.cnt      = EXP_CNT_W'(2);
        end
        else if (cfg.show_nonprinting) begin
            if (c < CH_SPACE && c != CH_TAB) begin
                e.bytes[0] = CH_CARET;
                e.bytes[1] = c + CTRL_OFS;
                e.cnt      = EXP_CNT_W'(2);
            end
            else if (c == CH_DEL) begin
                e.bytes[0] = CH_CARET;
                e.bytes[1] = CH_QMARK;
                e.cnt      = EXP_CNT_W'(2);
            end
            else if (c >= CH_HIGH && c < CH_META) begin
                e.bytes[0] = CH_M;
                e.bytes[1] = CH_DASH;
                e.bytes[2] = CH_CARET;
                e.bytes[3] = c - CTRL_OFS;
                e.cnt      = EXP_CNT_W'(4);
            end
            else if (c == CH_MAX) begin
                e.bytes[0] = CH_M;
                e.bytes[1] = CH_DASH;
                e.bytes[2] = CH_CARET;
                e.bytes[3] = CH_QMARK;
                e.cnt      = EXP_CNT_W'(4);
            end
            else if (c >= CH_META) begin
                e.bytes[0] = CH_M;
                e.bytes[1] = CH_DASH;
                e.bytes[2] = c - CH_HIGH;
                e.cnt      = EXP_CNT_W'(3);
            end
        end
        return e;
    endfunction

endpackage

[sv/tscf_front.sv]
// tscf_front: accepts input bytes, tracks line state and the BCD line
// counter, and turns each byte into a job for the queue.
// Depends on tscf_pkg.
module tscf_front (
    input  logic                clk,
    input  logic                rst_n,
    input  tscf_pkg::cfg_t      cfg,
    input  logic                in_valid,
    input  logic [7:0]          in_byte,
    input  logic                file_start,
    input  logic                q_full,
    output logic                push,
    output tscf_pkg::job_t      job
);

    logic                       at_line_start_reg, at_line_start_next;
    logic                       previous_blank_reg, previous_blank_next;
    logic [tscf_pkg::NUM_W-1:0] line_number_reg, line_number_next;

    logic                       accept;
    logic                       cur_start;
    logic                       cur_prev;
    logic [tscf_pkg::NUM_W-1:0] cur_num;
    logic                       blank;
    logic                       drop;
    logic                       do_num;

    always_comb
    begin
        accept    = in_valid && !q_full;
        // a new file restarts line state before the byte is handled
        cur_start = file_start ? 1'b1 : at_line_start_reg;
        cur_prev  = file_start ? 1'b0 : previous_blank_reg;
        cur_num   = file_start ? tscf_pkg::NUM_W'(1) : line_number_reg;
        blank     = (in_byte == tscf_pkg::CH_NL);
        drop      = cur_start && cfg.squeeze_blank && blank && cur_prev;
        // a dropped line uses no number
        do_num    = cur_start && !drop &&
                    (cfg.number_nonblank ? !blank : cfg.number_all);

        push        = accept && !drop;
        job.has_num = do_num;
        job.num     = cur_num;
        job.lead    = tscf_pkg::lead_mask(cur_num);
        job.exp     = tscf_pkg::expand(in_byte, cfg);

        at_line_start_next  = blank;
        previous_blank_next = cur_start ? blank : cur_prev;
        line_number_next    = do_num ? tscf_pkg::bcd_inc(cur_num) : cur_num;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            at_line_start_reg  <= 1'b1;
            previous_blank_reg <= 1'b0;
            line_number_reg    <= tscf_pkg::NUM_W'(1);
        end
        else if (accept) begin
            at_line_start_reg  <= at_line_start_next;
            previous_blank_reg <= previous_blank_next;
            line_number_reg    <= line_number_next;
        end
    end

endmodule

[sv/tscf_queue.sv]
// tscf_queue: small FIFO of jobs between the front and back parts.
// Depends on tscf_pkg.
module tscf_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tscf_pkg::job_t push_job,
    input  logic           pop,
    output logic           full,
    output logic           head_valid,
    output tscf_pkg::job_t head_job
);

    tscf_pkg::job_t                 mem [tscf_pkg::Q_DEPTH];
    logic [tscf_pkg::Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [tscf_pkg::Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [tscf_pkg::Q_CNT_W-1:0]   count_reg, count_next;

    always_comb
    begin
        full       = (count_reg == tscf_pkg::Q_CNT_W'(tscf_pkg::Q_DEPTH));
        head_valid = (count_reg != '0);
        head_job   = mem[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == tscf_pkg::Q_PTR_W'(tscf_pkg::Q_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == tscf_pkg::Q_PTR_W'(tscf_pkg::Q_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[sv/tscf_back.sv]
// tscf_back: walks the head job byte by byte (number digits, tab, then the
// byte expansion) into a registered output stage.
// Depends on tscf_pkg.
module tscf_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  tscf_pkg::job_t head_job,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [7:0]     out_byte,
    output logic           last
);

    logic [tscf_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic                           out_valid_reg, out_valid_next;
    logic [7:0]                     out_byte_reg, out_byte_next;
    logic                           last_reg, last_next;

    logic                           adv;
    logic [tscf_pkg::POS_W-1:0]     num_len;
    logic [tscf_pkg::POS_W-1:0]     total;
    logic [tscf_pkg::POS_W-1:0]     exp_pos;
    logic [7:0]                     digit_char;
    logic [7:0]                     sel_byte;
    logic                           final_byte;
    logic [3:0]                     dig;

    always_comb
    begin
        adv     = !out_valid_reg || !out_stall;
        num_len = head_job.has_num ?
                  tscf_pkg::POS_W'(tscf_pkg::NUMBER_DIGITS + 1) : '0;
        total   = num_len + tscf_pkg::POS_W'(head_job.exp.cnt);
        exp_pos = pos_reg - num_len;

        // digit shown at position pos_reg, most significant first
        digit_char = tscf_pkg::CH_SPACE;
        for (int i = 0; i < tscf_pkg::NUMBER_DIGITS; i++) begin
            dig = head_job.num[4*(tscf_pkg::NUMBER_DIGITS-1-i) +: 4];
            if (pos_reg == tscf_pkg::POS_W'(i)) begin
                digit_char = head_job.lead[tscf_pkg::NUMBER_DIGITS-1-i] ?
                             tscf_pkg::CH_SPACE : tscf_pkg::CH_ZERO + 8'(dig);
            end
        end

        if (pos_reg < num_len) begin
            sel_byte = (pos_reg == tscf_pkg::POS_W'(tscf_pkg::NUMBER_DIGITS)) ?
                       tscf_pkg::CH_TAB : digit_char;
        end
        else begin
            sel_byte = head_job.exp.bytes[exp_pos[tscf_pkg::EXP_IDX_W-1:0]];
        end
        final_byte = (pos_reg == total - 1'b1);

        pop            = adv && head_valid && final_byte;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        if (adv) begin
            out_valid_next = head_valid;
            if (head_valid) begin
                out_byte_next = sel_byte;
                last_next     = final_byte;
                pos_next      = final_byte ? '0 : pos_reg + 1'b1;
            end
        end

        out_valid = out_valid_reg;
        out_byte  = out_byte_reg;
        last      = last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
    end

endmodule

[sv/text_stream_cat_filter.sv]
// text_stream_cat_filter: top level of the cat-style text filter; holds the
// configuration registers and ties front, job queue and back together.
// Depends on tscf_pkg, tscf_front, tscf_queue, tscf_back.
//
//  Channel  Handshake             Payload              Direction
//  -------  --------------------  -------------------  ---------
//  in       in_valid / in_stall   in_byte, file_start  into block
//  out      out_valid / out_stall out_byte, last       out of block
//  cfg      psel/penable/pready   paddr, pwdata/prdata APB slave
//
//  An input byte yields 0 to 11 output bytes (number, tab, up to four
//  expansion bytes), sent one per cycle by the back sequencer while out_stall
//  is low, so input rate is one per cycle when no byte expands or is numbered.
//  The front classifies in the accept cycle and pushes a job into a
//  two-entry queue; in_stall is high only while that queue is full.
//  A dropped blank line pushes nothing and gives no output transaction.
//  Reset (rst_n, async, active low) clears config, line state, counter
//  (to one), queue and output valid.
//  out_stall holds the output register; the front keeps accepting until
//  the queue fills.
module text_stream_cat_filter (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    in_byte,
    input  logic                          file_start,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    out_byte,
    output logic                          last,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tscf_pkg::PADDR_W-1:0]  paddr,
    input  logic [tscf_pkg::PDATA_W-1:0]  pwdata,
    output logic [tscf_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    tscf_pkg::cfg_t                   cfg_reg;
    logic [tscf_pkg::REG_IDX_W-1:0]   reg_idx;
    logic                             cfg_write;
    logic                             rd_bit;

    logic                             push;
    tscf_pkg::job_t                   push_job;
    logic                             q_full;
    logic                             pop;
    logic                             head_valid;
    tscf_pkg::job_t                   head_job;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign reg_idx   = paddr[tscf_pkg::PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        unique case (reg_idx)
            tscf_pkg::REG_NUMBER_NONBLANK:  rd_bit = cfg_reg.number_nonblank;
            tscf_pkg::REG_NUMBER_ALL:       rd_bit = cfg_reg.number_all;
            tscf_pkg::REG_SQUEEZE_BLANK:    rd_bit = cfg_reg.squeeze_blank;
            tscf_pkg::REG_SHOW_ENDS:        rd_bit = cfg_reg.show_ends;
            tscf_pkg::REG_SHOW_TABS:        rd_bit = cfg_reg.show_tabs;
            tscf_pkg::REG_SHOW_NONPRINTING: rd_bit = cfg_reg.show_nonprinting;
            default:                        rd_bit = 1'b0;
        endcase
        prdata = {{(tscf_pkg::PDATA_W-1){1'b0}}, rd_bit};
    end

    // only bit 0 of a write is kept; unmapped addresses are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg <= '0;
        end
        else if (cfg_write) begin
            unique case (reg_idx)
                tscf_pkg::REG_NUMBER_NONBLANK:  cfg_reg.number_nonblank  <= pwdata[0];
                tscf_pkg::REG_NUMBER_ALL:       cfg_reg.number_all       <= pwdata[0];
                tscf_pkg::REG_SQUEEZE_BLANK:    cfg_reg.squeeze_blank    <= pwdata[0];
                tscf_pkg::REG_SHOW_ENDS:        cfg_reg.show_ends        <= pwdata[0];
                tscf_pkg::REG_SHOW_TABS:        cfg_reg.show_tabs        <= pwdata[0];
                tscf_pkg::REG_SHOW_NONPRINTING: cfg_reg.show_nonprinting <= pwdata[0];
                default:                        cfg_reg <= cfg_reg;
            endcase
        end
    end

    // ---------------- datapath ----------------
    assign in_stall = q_full;

    tscf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_byte    (in_byte),
        .file_start (file_start),
        .q_full     (q_full),
        .push       (push),
        .job        (push_job)
    );

    tscf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    tscf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .last       (last)
    );

endmodule
